// ===== rtl/rlf_pkg.sv =====
package rlf_pkg;

	// Storage widths of the debounce history and the entropy shifters.
	localparam int HIST_BITS = 16;
	localparam int ENT_BITS  = 16;

	localparam int NUM_LANES = 3;

	// Operating modes.
	localparam logic [1:0] MODE_STEADY = 2'd0;
	localparam logic [1:0] MODE_RANDOM = 2'd1;
	localparam logic [1:0] MODE_FAST   = 2'd2;
	localparam logic [1:0] MODE_BOUNCE = 2'd3;

	// Register indexes on the configuration port.
	localparam logic [2:0] REG_MIN_DUTY  = 3'd0;
	localparam logic [2:0] REG_MAX_DUTY  = 3'd1;
	localparam logic [2:0] REG_STEP_SIZE = 3'd2;
	localparam logic [2:0] REG_FAST_MULT = 3'd3;
	localparam logic [2:0] REG_TICKS     = 3'd4;

	// Reset values.
	localparam logic [15:0] MIN_DUTY_RST  = 16'd64;
	localparam logic [15:0] MAX_DUTY_RST  = 16'd65472;
	localparam logic [6:0]  STEP_SIZE_RST = 7'd16;
	localparam logic [3:0]  FAST_MULT_RST = 4'd4;
	localparam logic [8:0]  TICKS_RST     = 9'd4;
	localparam logic [15:0] DUTY_RST      = 16'd65472;
	localparam logic [7:0]  STEP_RST      = 8'hF0;
	localparam logic [15:0] TARGET_RST    = 16'd64;
	localparam logic [ENT_BITS-1:0] ENT_RST = ENT_BITS'(64);

	// Debounce patterns: a single released sample on top, or all released but the top.
	localparam logic [HIST_BITS-1:0] HIST_ALL  = '1;
	localparam logic [HIST_BITS-1:0] HIST_DOWN = HIST_ALL ^ (HIST_ALL >> 1);
	localparam logic [HIST_BITS-1:0] HIST_UP   = HIST_ALL >> 1;

	localparam logic [6:0] MAG_MAX = 7'd127;

	typedef struct packed {
		logic [15:0] min_duty;
		logic [15:0] max_duty;
		logic [6:0]  step_size;
		logic [3:0]  fast_mult;
		logic [8:0]  ticks;
	} cfg_t;

	// Per-item commands from the control unit to every lane.
	typedef struct packed {
		logic       adc_shift;
		logic       upd_random;
		logic       upd_bounce;
		logic [6:0] upd_mag;
		logic       reinit;
		logic       reinit_load;
		logic [6:0] init_mag;
	} lane_ctl_t;

	// Step magnitude of the fast random mode, saturated.
	function automatic logic [6:0] fast_mag(input logic [6:0] step, input logic [3:0] mult);
		logic [10:0] prod;
		prod = 11'(step) * 11'(mult);
		return (prod > 11'(MAG_MAX)) ? MAG_MAX : prod[6:0];
	endfunction

	// Clamp to the upper bound first, then to the lower bound.
	function automatic logic [15:0] clamp_duty(input logic signed [17:0] v,
			input logic [15:0] lo, input logic [15:0] hi);
		logic signed [17:0] lo_s;
		logic signed [17:0] hi_s;
		lo_s = $signed({2'b00, lo});
		hi_s = $signed({2'b00, hi});
		if (v >= hi_s) begin
			return hi;
		end else if (v <= lo_s) begin
			return lo;
		end else begin
			return v[15:0];
		end
	endfunction

endpackage

// ===== rtl/rlf_lane.sv =====
module rlf_lane (
	input  logic               clk,
	input  logic               arst_n,
	input  rlf_pkg::cfg_t      cfg,
	input  rlf_pkg::lane_ctl_t ctl,
	input  logic               sample_bit,
	output logic [15:0]        duty_nxt
);

	logic [15:0]                  duty_q;
	logic [7:0]                   step_q;
	logic [15:0]                  tgt_q;
	logic [rlf_pkg::ENT_BITS-1:0] ent_q;

	logic [7:0]                   step_n;
	logic [15:0]                  tgt_n;
	logic [rlf_pkg::ENT_BITS-1:0] ent_n;

	logic signed [17:0] sum;
	logic signed [17:0] tgt_s;
	logic signed [17:0] tmp;
	logic [15:0]        ent_ext;
	logic [15:0]        ent_cl;
	logic               hit;

	// Next channel state for the command of this cycle.
	always_comb begin
		sum      = $signed({2'b00, duty_q}) + $signed({{10{step_q[7]}}, step_q});
		tgt_s    = $signed({2'b00, tgt_q});
		ent_ext  = 16'(ent_q);
		ent_cl   = rlf_pkg::clamp_duty($signed({2'b00, ent_ext}), cfg.min_duty, cfg.max_duty);
		hit      = (!step_q[7] && (step_q != 8'd0) && (sum >= tgt_s)) ||
			(step_q[7] && (sum <= tgt_s));
		tmp      = sum;
		duty_nxt = duty_q;
		step_n   = step_q;
		tgt_n    = tgt_q;
		ent_n    = ent_q;

		if (ctl.adc_shift) begin
			ent_n = {ent_q[rlf_pkg::ENT_BITS-2:0], sample_bit};
		end

		// Random slew: on reaching the target, load a new one and turn the step.
		if (ctl.upd_random) begin
			if (hit) begin
				tmp   = tgt_s;
				tgt_n = ent_cl;
				if (ent_cl < tgt_q) begin
					step_n = 8'd0 - {1'b0, ctl.upd_mag};
				end else if (ent_cl > tgt_q) begin
					step_n = {1'b0, ctl.upd_mag};
				end
			end
			duty_nxt = rlf_pkg::clamp_duty(tmp, cfg.min_duty, cfg.max_duty);
		end

		// Bounce between the bounds.
		if (ctl.upd_bounce) begin
			if (sum <= $signed({2'b00, cfg.min_duty})) begin
				duty_nxt = cfg.min_duty;
				step_n   = {1'b0, cfg.step_size};
			end else if (sum >= $signed({2'b00, cfg.max_duty})) begin
				duty_nxt = cfg.max_duty;
				step_n   = 8'd0 - {1'b0, cfg.step_size};
			end else begin
				duty_nxt = sum[15:0];
			end
		end

		// Mode entry restarts from the top bound going down.
		if (ctl.reinit) begin
			duty_nxt = cfg.max_duty;
			step_n   = 8'd0 - {1'b0, ctl.init_mag};
			if (ctl.reinit_load) begin
				tgt_n = ent_ext;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_q <= rlf_pkg::DUTY_RST;
			step_q <= rlf_pkg::STEP_RST;
			tgt_q  <= rlf_pkg::TARGET_RST;
			ent_q  <= rlf_pkg::ENT_RST;
		end else begin
			duty_q <= duty_nxt;
			step_q <= step_n;
			tgt_q  <= tgt_n;
			ent_q  <= ent_n;
		end
	end

endmodule

// ===== rtl/rlf_ctrl.sv =====
module rlf_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  rlf_pkg::cfg_t      cfg,
	input  logic               accept,
	input  logic               kind,
	input  logic               button_level,
	output rlf_pkg::lane_ctl_t ctl,
	output logic [1:0]         mode_nxt,
	output logic               press
);

	logic [1:0]                    mode_q;
	logic                          released_q;
	logic [rlf_pkg::HIST_BITS-1:0] hist_q;
	logic [7:0]                    tick_cnt_q;

	logic                          tick;
	logic [rlf_pkg::HIST_BITS-1:0] hist_n;
	logic                          released_n;
	logic [7:0]                    tick_cnt_n;
	logic [8:0]                    cnt;
	logic [8:0]                    period;
	logic                          do_update;
	logic [6:0]                    fmag;

	// Debounce, update timing and mode sequencing for one transaction.
	always_comb begin
		tick       = accept && !kind;
		hist_n     = hist_q;
		released_n = released_q;
		tick_cnt_n = tick_cnt_q;
		press      = 1'b0;
		do_update  = 1'b0;
		fmag       = rlf_pkg::fast_mag(cfg.step_size, cfg.fast_mult);

		if (cfg.ticks == 9'd0) begin
			period = 9'd1;
		end else if (cfg.ticks > 9'd256) begin
			period = 9'd256;
		end else begin
			period = cfg.ticks;
		end
		cnt = {1'b0, tick_cnt_q} + 9'd1;

		if (tick) begin
			hist_n = {hist_q[rlf_pkg::HIST_BITS-2:0], button_level};
			if ((hist_n == rlf_pkg::HIST_DOWN) && released_q) begin
				released_n = 1'b0;
				press      = 1'b1;
			end else if ((hist_n == rlf_pkg::HIST_UP) && !released_q) begin
				released_n = 1'b1;
			end
			if (cnt >= period) begin
				tick_cnt_n = 8'd0;
				do_update  = 1'b1;
			end else begin
				tick_cnt_n = cnt[7:0];
			end
		end

		mode_nxt = press ? (mode_q + 2'd1) : mode_q;

		// The update uses the mode held before this tick.
		ctl.adc_shift   = accept && kind;
		ctl.upd_random  = do_update && ((mode_q == rlf_pkg::MODE_RANDOM) ||
			(mode_q == rlf_pkg::MODE_FAST));
		ctl.upd_bounce  = do_update && (mode_q == rlf_pkg::MODE_BOUNCE);
		ctl.upd_mag     = (mode_q == rlf_pkg::MODE_FAST) ? fmag : cfg.step_size;
		ctl.reinit      = press && (mode_nxt != rlf_pkg::MODE_STEADY);
		ctl.reinit_load = (mode_nxt == rlf_pkg::MODE_RANDOM) ||
			(mode_nxt == rlf_pkg::MODE_FAST);
		ctl.init_mag    = (mode_nxt == rlf_pkg::MODE_FAST) ? fmag : cfg.step_size;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= rlf_pkg::MODE_RANDOM;
			released_q <= 1'b1;
			hist_q     <= rlf_pkg::HIST_ALL;
			tick_cnt_q <= 8'd0;
		end else begin
			mode_q     <= mode_nxt;
			released_q <= released_n;
			hist_q     <= hist_n;
			tick_cnt_q <= tick_cnt_n;
		end
	end

	// A press always advances the mode by one.
	assert property (@(posedge clk) disable iff (!arst_n)
		press |=> (mode_q == $past(mode_q) + 2'd1))
		else $error("mode did not advance on press");

	// A press can only come while the button was seen released.
	assert property (@(posedge clk) disable iff (!arst_n)
		press |-> released_q)
		else $error("press while not released");

	// An ADC transaction never moves the mode or the tick counter.
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && kind) |=> ($stable(mode_q) && $stable(tick_cnt_q)))
		else $error("ADC transaction changed tick state");

endmodule

// ===== rtl/rgb_led_random_fade_controller_core.sv =====
// Channel  | Direction | Handshake                 | Payload
// input    | in        | in_valid / in_stall       | kind, button_level, sample_ch0..2
// output   | out       | out_valid / out_stall     | duty_ch0..2, mode_now, full_on, pressed
// config   | in        | psel, penable, pready     | paddr, pwdata, prdata (APB)
//
// One transaction is accepted per cycle unless in_stall is high; results enter the buffer.
// In the cycle of acceptance three lanes update the channel state, the control unit the control state.
// A two-entry output buffer (output register plus skid) decouples the two sides;
// in_stall rises only when both entries hold results. arst_n clears all state but
// the buffer payloads asynchronously; no clearing pass is needed after reset.
module rgb_led_random_fade_controller_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        kind,
	input  logic        button_level,
	input  logic [9:0]  sample_ch0,
	input  logic [9:0]  sample_ch1,
	input  logic [9:0]  sample_ch2,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] duty_ch0,
	output logic [15:0] duty_ch1,
	output logic [15:0] duty_ch2,
	output logic [1:0]  mode_now,
	output logic        full_on,
	output logic        pressed,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	rlf_pkg::cfg_t      cfg_q;
	rlf_pkg::lane_ctl_t lane_ctl;

	logic [2:0]  reg_idx;
	logic        cfg_wr;
	logic        accept;
	logic        pop;
	logic [1:0]  mode_nxt;
	logic        press;
	logic [15:0] duty_nxt [rlf_pkg::NUM_LANES];
	logic        sample_bit [rlf_pkg::NUM_LANES];

	logic        out_valid_q;
	logic [15:0] out_duty_q [rlf_pkg::NUM_LANES];
	logic [1:0]  out_mode_q;
	logic        out_press_q;
	logic        skid_valid_q;
	logic [15:0] skid_duty_q [rlf_pkg::NUM_LANES];
	logic [1:0]  skid_mode_q;
	logic        skid_press_q;

	// Configuration registers.
	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_duty  <= rlf_pkg::MIN_DUTY_RST;
			cfg_q.max_duty  <= rlf_pkg::MAX_DUTY_RST;
			cfg_q.step_size <= rlf_pkg::STEP_SIZE_RST;
			cfg_q.fast_mult <= rlf_pkg::FAST_MULT_RST;
			cfg_q.ticks     <= rlf_pkg::TICKS_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				rlf_pkg::REG_MIN_DUTY:  cfg_q.min_duty  <= pwdata[15:0];
				rlf_pkg::REG_MAX_DUTY:  cfg_q.max_duty  <= pwdata[15:0];
				rlf_pkg::REG_STEP_SIZE: cfg_q.step_size <= pwdata[6:0];
				rlf_pkg::REG_FAST_MULT: cfg_q.fast_mult <= pwdata[3:0];
				rlf_pkg::REG_TICKS:     cfg_q.ticks     <= pwdata[8:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			rlf_pkg::REG_MIN_DUTY:  prdata = 32'(cfg_q.min_duty);
			rlf_pkg::REG_MAX_DUTY:  prdata = 32'(cfg_q.max_duty);
			rlf_pkg::REG_STEP_SIZE: prdata = 32'(cfg_q.step_size);
			rlf_pkg::REG_FAST_MULT: prdata = 32'(cfg_q.fast_mult);
			rlf_pkg::REG_TICKS:     prdata = 32'(cfg_q.ticks);
			default:                prdata = 32'd0;
		endcase
	end

	// Handshakes.
	assign in_stall = skid_valid_q;
	assign accept   = in_valid && !skid_valid_q;
	assign pop      = out_valid_q && !out_stall;

	rlf_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.accept       (accept),
		.kind         (kind),
		.button_level (button_level),
		.ctl          (lane_ctl),
		.mode_nxt     (mode_nxt),
		.press        (press)
	);

	// One lane per color channel.
	assign sample_bit[0] = sample_ch0[0];
	assign sample_bit[1] = sample_ch1[0];
	assign sample_bit[2] = sample_ch2[0];

	for (genvar i = 0; i < rlf_pkg::NUM_LANES; i++) begin : g_lane
		rlf_lane u_lane (
			.clk        (clk),
			.arst_n     (arst_n),
			.cfg        (cfg_q),
			.ctl        (lane_ctl),
			.sample_bit (sample_bit[i]),
			.duty_nxt   (duty_nxt[i])
		);
	end

	// Merge the lane results with the mode into the output buffer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end
		end else if (accept) begin
			if (!out_valid_q || pop) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_duty_q  <= skid_duty_q;
				out_mode_q  <= skid_mode_q;
				out_press_q <= skid_press_q;
			end
		end else if (accept) begin
			if (!out_valid_q || pop) begin
				out_duty_q  <= duty_nxt;
				out_mode_q  <= mode_nxt;
				out_press_q <= press;
			end else begin
				skid_duty_q  <= duty_nxt;
				skid_mode_q  <= mode_nxt;
				skid_press_q <= press;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign duty_ch0  = out_duty_q[0];
	assign duty_ch1  = out_duty_q[1];
	assign duty_ch2  = out_duty_q[2];
	assign mode_now  = out_mode_q;
	assign full_on   = (out_mode_q == rlf_pkg::MODE_STEADY);
	assign pressed   = out_press_q;

	// The skid entry is only occupied behind a full output register.
	assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry holds data while output register is empty");

	// Every accepted transaction leaves a result in the buffer.
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid_q)
		else $error("accepted transaction produced no result");

	// A full skid entry is not overwritten while it waits.
	assert property (@(posedge clk) disable iff (!arst_n)
		(skid_valid_q && !pop) |=> (skid_valid_q && $stable(skid_mode_q)))
		else $error("skid entry lost");

endmodule

// ===== tb/sv/rgb_led_random_fade_controller_core_test.sv =====
module rgb_led_random_fade_controller_core_test;

	localparam int CYCLE_LIMIT = 500000;
	localparam int HOLD_CYCLES = 80;

	typedef struct packed {
		logic       kind;
		logic       level;
		logic [9:0] smp0;
		logic [9:0] smp1;
		logic [9:0] smp2;
	} stim_t;

	typedef struct packed {
		logic [15:0] d0;
		logic [15:0] d1;
		logic [15:0] d2;
		logic [1:0]  mode;
		logic        full;
		logic        pressed;
	} lamp_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        kind = 1'b0;
	logic        button_level = 1'b1;
	logic [9:0]  sample_ch0 = '0;
	logic [9:0]  sample_ch1 = '0;
	logic [9:0]  sample_ch2 = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [15:0] duty_ch0;
	logic [15:0] duty_ch1;
	logic [15:0] duty_ch2;
	logic [1:0]  mode_now;
	logic        full_on;
	logic        pressed;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	rgb_led_random_fade_controller_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.button_level(button_level),
		.sample_ch0(sample_ch0),
		.sample_ch1(sample_ch1),
		.sample_ch2(sample_ch2),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.duty_ch0(duty_ch0),
		.duty_ch1(duty_ch1),
		.duty_ch2(duty_ch2),
		.mode_now(mode_now),
		.full_on(full_on),
		.pressed(pressed),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// Pending stimulus and the duty results still owed by the block.
	stim_t stim_queue[$];
	lamp_t lamp_due[$];
	int    failures = 0;
	int    items_added = 0;
	logic  calm = 1'b0;
	int    hold_asked = 0;
	int    hold_done = 0;
	int    cycle_count = 0;

	// Mirror of the configuration registers.
	int lim_lo;
	int lim_hi;
	int step_cfg;
	int mult_cfg;
	int period_cfg;

	// Mirror of the fader state.
	int                            duty [3];
	int                            slope [3];
	int                            goal [3];
	logic [rlf_pkg::ENT_BITS-1:0]  noise [3];
	logic [rlf_pkg::HIST_BITS-1:0] hist;
	logic                          up;
	logic [1:0]                    mode;
	int                            tick_cnt;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function int clamp_to(int v);
		if (v >= lim_hi) begin
			return lim_hi;
		end else if (v <= lim_lo) begin
			return lim_lo;
		end
		return v;
	endfunction

	function int fast_size();
		int p;
		p = step_cfg * mult_cfg;
		return (p > 127) ? 127 : p;
	endfunction

	// Advance the mirrored fader by one transaction and return the duties it shows.
	function lamp_t fade_step(stim_t it);
		logic [9:0] smp [3];
		int ch;
		int mag;
		int period;
		int nxt;
		int tmp;
		logic pr;
		lamp_t r;
		smp[0] = it.smp0;
		smp[1] = it.smp1;
		smp[2] = it.smp2;
		pr = 1'b0;
		if (it.kind) begin
			for (ch = 0; ch < 3; ch++) begin
				noise[ch] = {noise[ch][rlf_pkg::ENT_BITS-2:0], smp[ch][0]};
			end
		end else begin
			// Debounce: a press needs one released sample followed by a full run of pressed ones.
			hist = {hist[rlf_pkg::HIST_BITS-2:0], it.level};
			if (hist == rlf_pkg::HIST_DOWN && up) begin
				up = 1'b0;
				pr = 1'b1;
			end else if (hist == rlf_pkg::HIST_UP && !up) begin
				up = 1'b1;
			end
			period = (period_cfg < 1) ? 1 : (period_cfg > 256) ? 256 : period_cfg;
			if (tick_cnt + 1 >= period) begin
				tick_cnt = 0;
				if (mode == rlf_pkg::MODE_RANDOM || mode == rlf_pkg::MODE_FAST) begin
					mag = (mode == rlf_pkg::MODE_FAST) ? fast_size() : step_cfg;
					for (ch = 0; ch < 3; ch++) begin
						tmp = duty[ch] + slope[ch];
						if ((slope[ch] > 0 && tmp >= goal[ch]) ||
								(slope[ch] < 0 && tmp <= goal[ch])) begin
							tmp = goal[ch];
							nxt = clamp_to(int'(noise[ch]));
							goal[ch] = nxt;
							if (nxt < tmp) begin
								slope[ch] = -mag;
							end else if (nxt > tmp) begin
								slope[ch] = mag;
							end
						end
						duty[ch] = clamp_to(tmp);
					end
				end else if (mode == rlf_pkg::MODE_BOUNCE) begin
					for (ch = 0; ch < 3; ch++) begin
						tmp = duty[ch] + slope[ch];
						if (tmp <= lim_lo) begin
							tmp = lim_lo;
							slope[ch] = step_cfg;
						end else if (tmp >= lim_hi) begin
							tmp = lim_hi;
							slope[ch] = -step_cfg;
						end
						duty[ch] = tmp;
					end
				end
			end else begin
				tick_cnt = (tick_cnt + 1) & 255;
			end
			// A press moves to the next mode; steady mode keeps the duties as they are.
			if (pr) begin
				mode = mode + 2'd1;
				if (mode != rlf_pkg::MODE_STEADY) begin
					mag = (mode == rlf_pkg::MODE_FAST) ? fast_size() : step_cfg;
					for (ch = 0; ch < 3; ch++) begin
						if (mode != rlf_pkg::MODE_BOUNCE) begin
							goal[ch] = int'(noise[ch]);
						end
						duty[ch] = lim_hi;
						slope[ch] = -mag;
					end
				end
			end
		end
		r.d0 = 16'(duty[0]);
		r.d1 = 16'(duty[1]);
		r.d2 = 16'(duty[2]);
		r.mode = mode;
		r.full = (mode == rlf_pkg::MODE_STEADY);
		r.pressed = pr;
		return r;
	endfunction

	task flag_mismatch(string what, int got, int want);
		$display("mismatch on %s: got %0d, expected %0d", what, got, want);
		failures++;
	endtask

	// Configuration write: setup cycle, then access cycle until pready.
	task cfg_write(logic [2:0] idx, logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			rlf_pkg::REG_MIN_DUTY:  lim_lo = int'(value[15:0]);
			rlf_pkg::REG_MAX_DUTY:  lim_hi = int'(value[15:0]);
			rlf_pkg::REG_STEP_SIZE: step_cfg = int'(value[6:0]);
			rlf_pkg::REG_FAST_MULT: mult_cfg = int'(value[3:0]);
			rlf_pkg::REG_TICKS:     period_cfg = int'(value[8:0]);
			default: ;
		endcase
	endtask

	task configure(int lo, int hi, int stp, int mult, int period);
		cfg_write(rlf_pkg::REG_MIN_DUTY, lo);
		cfg_write(rlf_pkg::REG_MAX_DUTY, hi);
		cfg_write(rlf_pkg::REG_STEP_SIZE, stp);
		cfg_write(rlf_pkg::REG_FAST_MULT, mult);
		cfg_write(rlf_pkg::REG_TICKS, period);
	endtask

	task queue_item(logic k, logic lvl, logic [9:0] a, logic [9:0] b, logic [9:0] c);
		stim_queue.push_back('{kind: k, level: lvl, smp0: a, smp1: b, smp2: c});
		items_added++;
	endtask

	task queue_adc();
		queue_item(1'b1, 1'($urandom), 10'($urandom), 10'($urandom), 10'($urandom));
	endtask

	// A tick, sometimes preceded by an ADC set.
	task queue_tick(logic lvl);
		if ($urandom_range(0, 4) == 0) begin
			queue_adc();
		end
		queue_item(1'b0, lvl, 10'($urandom), 10'($urandom), 10'($urandom));
	endtask

	// Wait until no transaction is pending or owed by the block.
	task wait_drained();
		do @(negedge clk);
		while (stim_queue.size() != 0 || in_valid || lamp_due.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// One random episode of stimulus; in half of the draws a clean press and release sequence.
	task add_episode();
		int sel;
		int n;
		int i;
		int b;
		int ch;
		logic [15:0] v [3];
		logic [9:0] s [3];
		sel = $urandom_range(0, 9);
		if (sel < 5) begin
			if ($urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 4);
				for (i = 0; i < n; i++) queue_tick(1'($urandom));
			end
			n = ($urandom_range(0, 5) == 0) ? $urandom_range(3, 14) : $urandom_range(15, 24);
			for (i = 0; i < n; i++) queue_tick(1'b0);
			n = ($urandom_range(0, 5) == 0) ? $urandom_range(3, 14) : $urandom_range(15, 24);
			for (i = 0; i < n; i++) queue_tick(1'b1);
		end else if (sel == 5) begin
			n = $urandom_range(4, 16);
			for (i = 0; i < n; i++) queue_tick(1'($urandom));
		end else if (sel == 6) begin
			n = $urandom_range(1, 16);
			for (i = 0; i < n; i++) queue_adc();
		end else if (sel == 7) begin
			n = $urandom_range(4, 20);
			for (i = 0; i < n; i++) queue_tick(1'b1);
		end else begin
			// Shift a full entropy word per channel, mostly inside the duty window.
			for (ch = 0; ch < 3; ch++) begin
				if (lim_lo <= lim_hi && $urandom_range(0, 3) != 0) begin
					v[ch] = 16'($urandom_range(lim_lo, lim_hi));
				end else begin
					v[ch] = 16'($urandom);
				end
			end
			for (b = rlf_pkg::ENT_BITS - 1; b >= 0; b--) begin
				for (ch = 0; ch < 3; ch++) begin
					s[ch] = {9'($urandom), v[ch][b]};
				end
				queue_item(1'b1, 1'($urandom), s[0], s[1], s[2]);
			end
		end
	endtask

	// Sender: offers queued transactions, holding each until accepted, with random gaps.
	int gap_left = 0;
	int quiet_tx = 0;
	always @(posedge clk) begin
		logic send;
		stim_t it;
		if (in_valid && !in_stall) begin
			lamp_due.push_back(fade_step('{kind: kind, level: button_level,
				smp0: sample_ch0, smp1: sample_ch1, smp2: sample_ch2}));
		end
		if (!in_valid || !in_stall) begin
			send = 1'b0;
			if (quiet_tx > 0) begin
				quiet_tx--;
			end
			if (gap_left > 0) begin
				gap_left--;
			end else if (arst_n && stim_queue.size() != 0) begin
				if (!calm && quiet_tx == 0 && $urandom_range(0, 9) == 0) begin
					gap_left = $urandom_range(0, 18);
				end else begin
					send = 1'b1;
					if (quiet_tx == 0 && $urandom_range(0, 49) == 0) begin
						quiet_tx = $urandom_range(20, 80);
					end
				end
			end
			if (send) begin
				it = stim_queue.pop_front();
				kind <= it.kind;
				button_level <= it.level;
				sample_ch0 <= it.smp0;
				sample_ch1 <= it.smp1;
				sample_ch2 <= it.smp2;
			end
			in_valid <= send;
		end
	end

	// Receiver stall: random bursts, quiet stretches, and a long hold on request.
	int hold_left = 0;
	int burst_left = 0;
	int quiet_rx = 0;
	always @(posedge clk) begin
		logic s;
		s = 1'b0;
		if (hold_left > 0) begin
			hold_left--;
			s = 1'b1;
		end else if (hold_asked != hold_done) begin
			hold_done++;
			hold_left = HOLD_CYCLES - 1;
			s = 1'b1;
		end else if (calm) begin
			s = 1'b0;
		end else if (quiet_rx > 0) begin
			quiet_rx--;
		end else if (burst_left > 0) begin
			burst_left--;
			s = 1'b1;
		end else if ($urandom_range(0, 7) == 0) begin
			burst_left = $urandom_range(0, 18);
			s = 1'b1;
		end else if ($urandom_range(0, 39) == 0) begin
			quiet_rx = $urandom_range(20, 80);
		end
		out_stall <= s;
	end

	// Compare each accepted result with the oldest prediction.
	always @(posedge clk) begin
		lamp_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (lamp_due.size() == 0) begin
				flag_mismatch("unexpected result", 1, 0);
			end else begin
				want = lamp_due.pop_front();
				if (duty_ch0 !== want.d0) flag_mismatch("duty_ch0", duty_ch0, want.d0);
				if (duty_ch1 !== want.d1) flag_mismatch("duty_ch1", duty_ch1, want.d1);
				if (duty_ch2 !== want.d2) flag_mismatch("duty_ch2", duty_ch2, want.d2);
				if (mode_now !== want.mode) flag_mismatch("mode_now", mode_now, want.mode);
				if (full_on !== want.full) flag_mismatch("full_on", full_on, want.full);
				if (pressed !== want.pressed) flag_mismatch("pressed", pressed, want.pressed);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("rgb_led_random_fade_controller_core_test failed");
			$finish;
		end
	end

	initial begin
		int plan [8][5];
		int ph;
		int ch;
		int lo;
		plan = '{
			'{1000, 1400, 127, 8, 1},
			'{0, 65535, 100, 8, 2},
			'{2000, 1000, 50, 3, 1},
			'{500, 700, 0, 0, 0},
			'{30000, 30300, 9, 15, 511},
			'{65535, 0, 1, 1, 3},
			'{0, 0, 127, 1, 1},
			'{64, 65472, 16, 4, 4}
		};

		// Mirror starts from the reset state.
		lim_lo = int'(rlf_pkg::MIN_DUTY_RST);
		lim_hi = int'(rlf_pkg::MAX_DUTY_RST);
		step_cfg = int'(rlf_pkg::STEP_SIZE_RST);
		mult_cfg = int'(rlf_pkg::FAST_MULT_RST);
		period_cfg = int'(rlf_pkg::TICKS_RST);
		mode = rlf_pkg::MODE_RANDOM;
		up = 1'b1;
		hist = rlf_pkg::HIST_ALL;
		tick_cnt = 0;
		for (ch = 0; ch < 3; ch++) begin
			duty[ch] = int'(rlf_pkg::DUTY_RST);
			slope[ch] = int'($signed(rlf_pkg::STEP_RST));
			goal[ch] = int'(rlf_pkg::TARGET_RST);
			noise[ch] = rlf_pkg::ENT_RST;
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: sample extremes, both button levels, updates at the reset period.
		queue_item(1'b1, 1'b0, 10'h000, 10'h000, 10'h000);
		queue_item(1'b1, 1'b1, 10'h3FF, 10'h3FF, 10'h3FF);
		queue_item(1'b1, 1'b0, 10'h2AA, 10'h155, 10'h3FF);
		queue_item(1'b1, 1'b1, 10'h155, 10'h2AA, 10'h000);
		queue_item(1'b0, 1'b1, 10'h3FF, 10'h000, 10'h3FF);
		queue_item(1'b0, 1'b0, 10'h000, 10'h3FF, 10'h000);
		queue_item(1'b0, 1'b1, 10'h2AA, 10'h2AA, 10'h2AA);
		queue_item(1'b0, 1'b1, 10'h155, 10'h155, 10'h155);
		queue_item(1'b0, 1'b0, 10'h3FF, 10'h3FF, 10'h3FF);
		queue_item(1'b1, 1'b1, 10'h001, 10'h000, 10'h001);
		queue_item(1'b0, 1'b1, 10'h000, 10'h000, 10'h000);
		queue_item(1'b0, 1'b1, 10'h3FE, 10'h3FE, 10'h3FE);
		queue_item(1'b0, 1'b1, 10'h000, 10'h000, 10'h000);
		queue_item(1'b0, 1'b1, 10'h3FF, 10'h3FF, 10'h3FF);
		wait_drained();

		// Phases of fixed and random settings; the last one runs without idling.
		for (ph = 0; ph < 10; ph++) begin
			if (ph == 9) begin
				@(posedge clk);
				calm <= 1'b1;
			end
			if (ph < 8) begin
				configure(plan[ph][0], plan[ph][1], plan[ph][2], plan[ph][3], plan[ph][4]);
			end else begin
				lo = $urandom_range(0, 60000);
				configure(lo, lo + $urandom_range(0, 5000), $urandom_range(1, 127),
					$urandom_range(1, 8), $urandom_range(1, 6));
			end
			items_added = 0;
			while (items_added < 64) add_episode();
			if (ph == 2) begin
				@(posedge clk);
				hold_asked <= hold_asked + 1;
			end
			wait_drained();
		end

		repeat (10) @(posedge clk);
		if (failures == 0) begin
			$display("rgb_led_random_fade_controller_core_test passed");
		end else begin
			$display("rgb_led_random_fade_controller_core_test failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/rlf_pkg.sv
rtl/rlf_lane.sv
rtl/rlf_ctrl.sv
rtl/rgb_led_random_fade_controller_core.sv
tb/sv/rgb_led_random_fade_controller_core_test.sv
